// ===== rtl/lkv_pkg.sv =====
// Shared types, constants and helpers for the LRU key-value cache.
package lkv_pkg;

  localparam int MaxEntries = 16;
  localparam int SlotBits   = 4;
  localparam int RankBits   = 4;
  localparam int CountBits  = 5;
  localparam int CapBits    = 5;
  localparam int KeyBits    = 32;
  localparam int ValueBits  = 32;

  localparam logic [CapBits-1:0] CapReset = 5'd16;

  // Request kinds
  localparam logic ReqGet = 1'b0;
  localparam logic ReqPut = 1'b1;

  typedef logic [SlotBits-1:0]  slot_idx_t;
  typedef logic [RankBits-1:0]  rank_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [ValueBits-1:0] value_t;

  // One registered request item
  typedef struct packed {
    logic   is_put;
    key_t   key;
    value_t value;
  } req_t;

  // Search results handed from the lookup to the slot store
  typedef struct packed {
    logic      hit;
    slot_idx_t hit_idx;
    logic      evict;
    slot_idx_t evict_idx;
    logic      free_ok;
    slot_idx_t free_idx;
  } lookup_t;

  // Capacity register clamped to 1 .. MaxEntries
  function automatic count_t eff_capacity(logic [CapBits-1:0] cap);
    count_t c;
    c = cap;
    if (c == '0) c = count_t'(1);
    if (c > count_t'(MaxEntries)) c = count_t'(MaxEntries);
    return c;
  endfunction

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Channels: request in (in_valid/in_ready; req_type, req_key, put_value),
// result out (out_valid/out_ready; key_found, read_value, entry_evicted),
// and a capacity write port (cfg_valid/cfg_ready/cfg_data, always ready).
// Each request gives exactly one result.
// A taken request waits in the input register; its result then goes to
// the output register. Throughput: one request per cycle while out_ready
// is high. Key compare over all 16 slots, the rank update and the
// eviction pick are one combinational pass between the input register
// and the output register, and the state written in that pass is seen by
// the next request in the following cycle.
// Reset: all slots become invalid, live count zero, capacity 16. No
// clearing pass is needed; the first request can follow reset at once.
// Stall: when out_ready is low the result is held and the request in the
// input register waits; in_ready drops only while both registers are full.
// The user must write capacity only while no request is in flight; the block does not enforce it.
module lru_key_value_cache
  import lkv_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic signed [KeyBits-1:0]   req_key,
  input  logic signed [ValueBits-1:0] put_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       key_found,
  output logic signed [ValueBits-1:0] read_value,
  output logic                       entry_evicted,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CapBits-1:0]         cfg_data
);

  req_t                  req;
  logic                  req_full;
  logic                  advance;
  logic [CapBits-1:0]    capacity;
  lookup_t               lk;
  logic [MaxEntries-1:0] slot_valid;
  key_t                  slot_key   [MaxEntries];
  value_t                slot_value [MaxEntries];
  rank_t                 slot_rank  [MaxEntries];
  count_t                live_count;

  // Handshake
  assign advance   = req_full && (!out_valid || out_ready);
  assign in_ready  = !req_full || advance;
  assign cfg_ready = 1'b1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapReset;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_full <= 1'b1;
    end else if (advance) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.is_put <= (req_type == ReqPut);
      req.key    <= key_t'(req_key);
      req.value  <= value_t'(put_value);
    end
  end

  lkv_lookup u_lookup (
    .req        (req),
    .capacity   (capacity),
    .live_count (live_count),
    .slot_valid (slot_valid),
    .slot_key   (slot_key),
    .slot_rank  (slot_rank),
    .lk         (lk)
  );

  lkv_slots u_slots (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .req        (req),
    .lk         (lk),
    .slot_valid (slot_valid),
    .slot_key   (slot_key),
    .slot_value (slot_value),
    .slot_rank  (slot_rank),
    .live_count (live_count)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_found     <= lk.hit;
      read_value    <= (!req.is_put && lk.hit) ? slot_value[lk.hit_idx] : '0;
      entry_evicted <= lk.evict;
    end
  end

endmodule

// ===== rtl/lkv_lookup.sv =====
// Parallel key match, least-recent slot pick and free slot search.
module lkv_lookup
  import lkv_pkg::*;
(
  input  req_t                 req,
  input  logic [CapBits-1:0]   capacity,
  input  count_t               live_count,
  input  logic [MaxEntries-1:0] slot_valid,
  input  key_t                 slot_key  [MaxEntries],
  input  rank_t                slot_rank [MaxEntries],
  output lookup_t              lk
);

  logic [MaxEntries-1:0] valid_left;
  rank_t                 oldest_rank;

  assign oldest_rank = rank_t'(live_count - count_t'(1));

  always_comb begin
    lk = '0;

    // Key match: lowest matching slot wins
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == req.key) begin
        lk.hit     = 1'b1;
        lk.hit_idx = slot_idx_t'(i);
      end
    end

    // Eviction needed for a new key at or over capacity
    lk.evict = req.is_put && !lk.hit && (live_count >= eff_capacity(capacity));

    // Least recent live slot holds the highest rank, live_count - 1
    for (int i = 0; i < MaxEntries; i++) begin
      if (slot_valid[i] && slot_rank[i] == oldest_rank) lk.evict_idx = slot_idx_t'(i);
    end

    // Occupancy after a possible eviction
    valid_left = slot_valid;
    if (lk.evict) valid_left[lk.evict_idx] = 1'b0;

    // Lowest free slot
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (!valid_left[i]) begin
        lk.free_ok  = 1'b1;
        lk.free_idx = slot_idx_t'(i);
      end
    end
  end

endmodule

// ===== rtl/lkv_slots.sv =====
// Slot store: keys, values, valid bits, recency ranks and live count.
module lkv_slots
  import lkv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  req_t                  req,
  input  lookup_t               lk,
  output logic [MaxEntries-1:0] slot_valid,
  output key_t                  slot_key   [MaxEntries],
  output value_t                slot_value [MaxEntries],
  output rank_t                 slot_rank  [MaxEntries],
  output count_t                live_count
);

  logic [MaxEntries-1:0] slot_valid_next;
  key_t                  slot_key_next   [MaxEntries];
  value_t                slot_value_next [MaxEntries];
  rank_t                 slot_rank_next  [MaxEntries];
  count_t                live_count_next;
  rank_t                 hit_rank;

  assign hit_rank = slot_rank[lk.hit_idx];

  // Next state for the item being retired
  always_comb begin
    slot_valid_next = slot_valid;
    slot_key_next   = slot_key;
    slot_value_next = slot_value;
    slot_rank_next  = slot_rank;
    live_count_next = live_count;
    if (advance) begin
      if (lk.hit) begin
        // touch: more recent live slots age by one
        for (int i = 0; i < MaxEntries; i++) begin
          if (slot_valid[i] && slot_rank[i] < hit_rank) slot_rank_next[i] = slot_rank[i] + 1'b1;
        end
        slot_rank_next[lk.hit_idx] = '0;
        if (req.is_put) slot_value_next[lk.hit_idx] = req.value;
      end else if (req.is_put) begin
        if (lk.evict) begin
          slot_valid_next[lk.evict_idx] = 1'b0;
          slot_rank_next[lk.evict_idx]  = '0;
        end
        if (lk.free_ok) begin
          for (int i = 0; i < MaxEntries; i++) begin
            if (slot_valid_next[i]) slot_rank_next[i] = slot_rank_next[i] + 1'b1;
          end
          slot_valid_next[lk.free_idx] = 1'b1;
          slot_key_next[lk.free_idx]   = req.key;
          slot_value_next[lk.free_idx] = req.value;
          slot_rank_next[lk.free_idx]  = '0;
        end
        live_count_next = live_count - count_t'(lk.evict) + count_t'(lk.free_ok);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      live_count <= '0;
      for (int i = 0; i < MaxEntries; i++) slot_rank[i] <= '0;
    end else begin
      slot_valid <= slot_valid_next;
      live_count <= live_count_next;
      slot_rank  <= slot_rank_next;
    end
  end

  // Payload, only read behind a valid bit
  always_ff @(posedge clk) begin
    slot_key   <= slot_key_next;
    slot_value <= slot_value_next;
  end

endmodule

// ===== rtl/lkv_checker.sv =====
// Port-level checks for the LRU key-value cache, bound to the top level.
module lkv_checker
  import lkv_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       key_found,
  input logic signed [ValueBits-1:0] read_value,
  input logic                       entry_evicted
);

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // An empty output side never blocks a new item
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready with the output register empty");

  // An eviction only happens for a put of a new key
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_evicted |-> !key_found && read_value == '0)
    else $error("eviction reported with a hit or a read value");

  // A miss never returns data
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_found |-> read_value == '0)
    else $error("nonzero read value on a miss");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_value)
      && $stable(key_found) && $stable(entry_evicted))
    else $error("result changed while stalled");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

// ===== test/lru_key_value_cache_tb.sv =====
// Testbench for the LRU key-value cache: directed table plus random requests checked against a predictor.
module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int KeyPoolSize = 24;
  localparam int NumSegs     = 6;
  localparam int NumRows     = 16;
  localparam int MaxReports  = 50;

  // One result item
  typedef struct packed {
    logic   found;
    value_t rd;
    logic   evicted;
  } reply_t;

  // One directed stimulus row; reply is used only when typed is set
  typedef struct packed {
    logic   put;
    key_t   key;
    value_t val;
    logic   typed;
    reply_t reply;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                req_type = ReqGet;
  key_t                req_key = '0;
  value_t              put_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                key_found;
  value_t              read_value;
  logic                entry_evicted;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CapBits-1:0]  cfg_data = '0;

  // Typed expectation travels with the item it belongs to
  logic   row_typed = 1'b0;
  reply_t row_exp = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int mismatch_count = 0;

  reply_t pending_replies[$];
  key_t   key_pool[KeyPoolSize];

  // Capacity and idling per random segment
  logic [CapBits-1:0] seg_cap[NumSegs]      = '{5'd31, 5'd0, 5'd5, 5'd16, 5'd3, 5'd17};
  int                 seg_items[NumSegs]    = '{150, 80, 150, 200, 120, 200};
  int                 seg_send_pct[NumSegs] = '{20, 20, 49, 49, 0, 0};
  int                 seg_recv_pct[NumSegs] = '{49, 49, 20, 20, 0, 0};

  // Predictor state
  key_t               mdl_key[MaxEntries];
  value_t             mdl_value[MaxEntries];
  logic               mdl_valid[MaxEntries];
  int                 mdl_rank[MaxEntries];
  int                 mdl_live;
  logic [CapBits-1:0] mdl_cap;

  lru_key_value_cache u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .req_key      (req_key),
    .put_value    (put_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_found    (key_found),
    .read_value   (read_value),
    .entry_evicted(entry_evicted),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Apply one request to the predicted cache and return its result
  function automatic reply_t lru_lookup(input logic is_put, input key_t k, input value_t v);
    reply_t r;
    int hit_slot;
    int hit_rank;
    int free_slot;
    int old_slot;
    int old_rank;
    int cap_now;
    r = '0;
    hit_slot = -1;
    for (int i = 0; i < MaxEntries; i++)
      if (mdl_valid[i] && mdl_key[i] == k && hit_slot < 0) hit_slot = i;
    r.found = (hit_slot >= 0);
    if (hit_slot >= 0) begin
      if (is_put == ReqGet) r.rd = mdl_value[hit_slot];
      else mdl_value[hit_slot] = v;
      // promote hit entry, age the ones that were more recent
      hit_rank = mdl_rank[hit_slot];
      for (int i = 0; i < MaxEntries; i++)
        if (mdl_valid[i] && mdl_rank[i] < hit_rank) mdl_rank[i]++;
      mdl_rank[hit_slot] = 0;
    end else if (is_put == ReqPut) begin
      cap_now = (mdl_cap == 0) ? 1 : (mdl_cap > MaxEntries) ? MaxEntries : int'(mdl_cap);
      if (mdl_live >= cap_now) begin
        // oldest entry goes; ties resolve to the highest slot
        old_slot = -1;
        old_rank = 0;
        for (int i = 0; i < MaxEntries; i++)
          if (mdl_valid[i] && (old_slot < 0 || mdl_rank[i] >= old_rank)) begin
            old_slot = i;
            old_rank = mdl_rank[i];
          end
        if (old_slot >= 0) begin
          mdl_valid[old_slot] = 1'b0;
          mdl_rank[old_slot] = 0;
          mdl_live--;
        end
        r.evicted = 1'b1;
      end
      // new key lands in the lowest free slot as most recent
      free_slot = -1;
      for (int i = 0; i < MaxEntries; i++)
        if (!mdl_valid[i] && free_slot < 0) free_slot = i;
      if (free_slot >= 0) begin
        for (int i = 0; i < MaxEntries; i++)
          if (mdl_valid[i]) mdl_rank[i]++;
        mdl_valid[free_slot] = 1'b1;
        mdl_key[free_slot] = k;
        mdl_value[free_slot] = v;
        mdl_rank[free_slot] = 0;
        mdl_live++;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MaxReports) $display("ERROR cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Present one request after a random gap and hold it until taken
  task automatic send_req(input logic kind, input key_t k, input value_t v, input logic typed,
                          input reply_t exp_reply);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= kind;
    req_key   <= k;
    put_value <= v;
    row_typed <= typed;
    row_exp   <= exp_reply;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapBits-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Track accepted config writes and requests
  always @(posedge clk) begin
    reply_t predicted;
    if (rst) begin
      for (int i = 0; i < MaxEntries; i++) begin
        mdl_key[i] = '0;
        mdl_value[i] = '0;
        mdl_valid[i] = 1'b0;
        mdl_rank[i] = 0;
      end
      mdl_live = 0;
      mdl_cap = CapReset;
    end else begin
      if (cfg_valid && cfg_ready) mdl_cap = cfg_data;
      if (in_valid && in_ready) begin
        predicted = lru_lookup(req_type, req_key, put_value);
        pending_replies.push_back(row_typed ? row_exp : predicted);
      end
    end
  end

  // Receiver: random stalls and result check
  always @(posedge clk) begin
    reply_t want;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = pending_replies.pop_front();
        if (key_found !== want.found)
          flag_mismatch($sformatf("key_found got %b want %b", key_found, want.found));
        if (read_value !== want.rd)
          flag_mismatch($sformatf("read_value got %h want %h", read_value, want.rd));
        if (entry_evicted !== want.evicted)
          flag_mismatch($sformatf("entry_evicted got %b want %b", entry_evicted, want.evicted));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows[NumRows];
    logic      kind;
    key_t      pick;
    // Directed rows run at capacity 2 so eviction shows up early
    dir_rows = '{
      '{ReqGet, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},  // empty after reset
      '{ReqGet, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
      '{ReqPut, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
      '{ReqPut, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
      '{ReqGet, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h8000_0000, 1'b0}},
      '{ReqPut, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b1}},  // full: evict
      '{ReqGet, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},  // evicted one
      '{ReqGet, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
      '{ReqPut, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 1'b0}},  // update
      '{ReqPut, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, '0},
      '{ReqGet, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
      '{ReqGet, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h1234_5678, 1'b0}},
      '{ReqGet, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 1'b0}},
      '{ReqPut, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 1'b1, '{1'b1, 32'h0, 1'b0}},
      '{ReqPut, 32'h0000_0001, 32'hF0F0_F0F0, 1'b0, '0},
      '{ReqGet, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
    };

    // Small key pool keeps the hit rate up; extremes first
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'hFFFF_FFFF;
    for (int i = 5; i < KeyPoolSize; i++) key_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 20;
    recv_idle_pct = 49;
    write_capacity(5'd2);
    foreach (dir_rows[i])
      send_req(dir_rows[i].put, dir_rows[i].key, dir_rows[i].val, dir_rows[i].typed,
               dir_rows[i].reply);
    in_valid <= 1'b0;
    wait_drained();

    // Random segments; capacity changes only once the pipe is empty
    for (int s = 0; s < NumSegs; s++) begin
      send_idle_pct = seg_send_pct[s];
      recv_idle_pct = seg_recv_pct[s];
      write_capacity(seg_cap[s]);
      for (int n = 0; n < seg_items[s]; n++) begin
        kind = ($urandom_range(99) < 45) ? ReqPut : ReqGet;
        pick = ($urandom_range(9) == 0) ? key_t'($urandom)
                                        : key_pool[$urandom_range(KeyPoolSize - 1)];
        send_req(kind, pick, value_t'($urandom), 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
